>>> rtl/cgbq_pkg.sv
// cgbq_pkg: beat types and operation codes for the clamped gain bucket queue
// used by clamped_gain_bucket_queue_core
package cgbq_pkg;

  localparam logic [2:0] FUNC_INSERT = 3'd0;
  localparam logic [2:0] FUNC_REMOVE = 3'd1;
  localparam logic [2:0] FUNC_UPDATE = 3'd2;
  localparam logic [2:0] FUNC_POP    = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;

  localparam logic [6:0] GAIN_LIMIT_RESET = 7'd127;
  localparam logic       REG_GAIN_LIMIT   = 1'b0;

  typedef struct packed {
    logic [2:0]         func;
    logic [9:0]         node;
    logic signed [15:0] gain;
  } in_beat_t;

  typedef struct packed {
    logic              found;
    logic [9:0]        node_out;
    logic signed [7:0] gain_out;
    logic [10:0]       node_count;
  } out_beat_t;

endpackage

>>> rtl/cgbq_ram.sv
// cgbq_ram: generic simple dual port ram, one write port, one registered read port
// no package dependency
module cgbq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

>>> rtl/clamped_gain_bucket_queue_core.sv
// clamped_gain_bucket_queue_core: gain bucket queue, uses cgbq_pkg and two cgbq_ram instances
// insert and update link the node at the head of its bucket, remove and update unlink it first,
//   pop scans buckets down from the top and removes the head found, clear sweeps both rams
// one item at a time: in_stall is high until the result beat is registered, and a stalled
//   result holds the core
// reset: synchronous, then a clearing pass over both rams with in_stall high
module clamped_gain_bucket_queue_core #(
  parameter int NODE_COUNT = 1024,
  parameter int GAIN_MAX   = 127
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cgbq_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cgbq_pkg::out_beat_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import cgbq_pkg::*;

  localparam int BUCKETS = 2 * GAIN_MAX + 1;
  localparam int NIW     = $clog2(NODE_COUNT);
  localparam int LW      = $clog2(NODE_COUNT + 1);
  localparam int BW      = $clog2(BUCKETS);
  localparam int EW      = 1 + BW + 2 * LW;
  localparam int SWEEP   = (NODE_COUNT > BUCKETS) ? NODE_COUNT : BUCKETS;
  localparam int CW      = $clog2(SWEEP);
  localparam logic [LW-1:0] NIL = LW'(NODE_COUNT);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD_N  = 4'd1;
  localparam logic [3:0] S_CK_N  = 4'd2;
  localparam logic [3:0] S_RM_A  = 4'd3;
  localparam logic [3:0] S_RM_P  = 4'd4;
  localparam logic [3:0] S_RM_B  = 4'd5;
  localparam logic [3:0] S_RM_Q  = 4'd6;
  localparam logic [3:0] S_RM_C  = 4'd7;
  localparam logic [3:0] S_IN_H  = 4'd8;
  localparam logic [3:0] S_IN_W  = 4'd9;
  localparam logic [3:0] S_SC_RD = 4'd10;
  localparam logic [3:0] S_SC_CK = 4'd11;
  localparam logic [3:0] S_CL    = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0]           state_r, state_nxt;
  logic [2:0]           op_r, op_nxt;
  logic [LW-1:0]        node_r, node_nxt;
  logic signed [15:0]   gain_r, gain_nxt;
  logic [LW-1:0]        p_r, p_nxt, q_r, q_nxt;
  logic [BW-1:0]        b_r, b_nxt;
  logic signed [BW:0]   tb_r, tb_nxt;
  logic [LW-1:0]        cnt_r, cnt_nxt;
  logic [6:0]           lim_r;
  logic [CW-1:0]        clr_r, clr_nxt;
  logic                 boot_r, boot_nxt;
  logic                 found_r, found_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_beat_t            out_r, out_nxt;

  logic                 nm_we, hm_we;
  logic [NIW-1:0]       nm_waddr, nm_raddr;
  logic [EW-1:0]        nm_wdata, nm_rdata;
  logic [BW-1:0]        hm_waddr, hm_raddr;
  logic [LW-1:0]        hm_wdata, hm_rdata;

  logic [16:0]          lim_eff;
  logic signed [17:0]   g_ext, g_lim, g_clamp, bkt_sum, top_clear, gout_sum;
  logic [BW-1:0]        bkt_in;
  logic                 node_ok;
  logic                 n_pres;
  logic [BW-1:0]        n_bkt;
  logic [LW-1:0]        n_nxt, n_prv;

  cgbq_ram #(.W(EW), .D(NODE_COUNT)) u_node_ram (
    .clk(clk), .we(nm_we), .waddr(nm_waddr), .wdata(nm_wdata),
    .raddr(nm_raddr), .rdata(nm_rdata)
  );

  cgbq_ram #(.W(LW), .D(BUCKETS)) u_head_ram (
    .clk(clk), .we(hm_we), .waddr(hm_waddr), .wdata(hm_wdata),
    .raddr(hm_raddr), .rdata(hm_rdata)
  );

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_GAIN_LIMIT) ? {25'd0, lim_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= GAIN_LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_GAIN_LIMIT) begin
      lim_r <= cfg_pwdata[6:0];
    end
  end

  // gain clamp to bucket index
  assign lim_eff   = (17'(lim_r) > 17'(GAIN_MAX)) ? 17'(GAIN_MAX) : 17'(lim_r);
  assign g_ext     = 18'(gain_r);
  assign g_lim     = signed'({1'b0, lim_eff});
  assign g_clamp   = (g_ext > g_lim) ? g_lim : ((g_ext < -g_lim) ? -g_lim : g_ext);
  assign bkt_sum   = g_clamp + 18'(GAIN_MAX);
  assign bkt_in    = bkt_sum[BW-1:0];
  assign top_clear = 18'(GAIN_MAX) - g_lim - 18'sd1;
  assign gout_sum  = 18'(tb_r) - 18'(GAIN_MAX);
  assign node_ok   = 32'(in_data.node) < NODE_COUNT;

  assign n_pres = nm_rdata[EW-1];
  assign n_bkt  = nm_rdata[2*LW +: BW];
  assign n_nxt  = nm_rdata[LW +: LW];
  assign n_prv  = nm_rdata[0 +: LW];

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    node_nxt      = node_r;
    gain_nxt      = gain_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    b_nxt         = b_r;
    tb_nxt        = tb_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    boot_nxt      = boot_r;
    found_nxt     = found_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    nm_we         = 1'b0;
    nm_waddr      = node_r[NIW-1:0];
    nm_wdata      = nm_rdata;
    nm_raddr      = node_r[NIW-1:0];
    hm_we         = 1'b0;
    hm_waddr      = b_r;
    hm_wdata      = q_r;
    hm_raddr      = b_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.func;
          node_nxt  = LW'(in_data.node);
          gain_nxt  = in_data.gain;
          found_nxt = 1'b0;
          unique case (in_data.func)
            FUNC_INSERT, FUNC_REMOVE, FUNC_UPDATE:
              state_nxt = node_ok ? S_RD_N : S_DONE;
            FUNC_POP:
              state_nxt = (cnt_r == '0) ? S_DONE : S_SC_RD;
            FUNC_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = S_CL;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RD_N: begin
        nm_raddr  = node_r[NIW-1:0];
        state_nxt = S_CK_N;
      end
      S_CK_N: begin
        if (op_r == FUNC_INSERT) begin
          if (n_pres) begin
            state_nxt = S_DONE;
          end else begin
            hm_raddr  = bkt_in;
            b_nxt     = bkt_in;
            state_nxt = S_IN_H;
          end
        end else if (!n_pres) begin
          if (op_r == FUNC_UPDATE) begin
            hm_raddr  = bkt_in;
            b_nxt     = bkt_in;
            state_nxt = S_IN_H;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          p_nxt     = n_prv;
          q_nxt     = n_nxt;
          b_nxt     = n_bkt;
          state_nxt = S_RM_A;
        end
      end
      S_RM_A: begin
        if (p_r == NIL) begin
          hm_we     = 1'b1;
          hm_waddr  = b_r;
          hm_wdata  = q_r;
          state_nxt = S_RM_B;
        end else begin
          nm_raddr  = p_r[NIW-1:0];
          state_nxt = S_RM_P;
        end
      end
      S_RM_P: begin
        nm_we     = 1'b1;
        nm_waddr  = p_r[NIW-1:0];
        nm_wdata  = {nm_rdata[EW-1:2*LW], q_r, nm_rdata[LW-1:0]};
        state_nxt = S_RM_B;
      end
      S_RM_B: begin
        if (q_r != NIL) begin
          nm_raddr  = q_r[NIW-1:0];
          state_nxt = S_RM_Q;
        end else begin
          state_nxt = S_RM_C;
        end
      end
      S_RM_Q: begin
        nm_we     = 1'b1;
        nm_waddr  = q_r[NIW-1:0];
        nm_wdata  = {nm_rdata[EW-1:LW], p_r};
        state_nxt = S_RM_C;
      end
      S_RM_C: begin
        nm_we    = 1'b1;
        nm_waddr = node_r[NIW-1:0];
        nm_wdata = {1'b0, b_r, q_r, p_r};
        cnt_nxt  = cnt_r - LW'(1);
        if (op_r == FUNC_UPDATE) begin
          hm_raddr  = bkt_in;
          b_nxt     = bkt_in;
          state_nxt = S_IN_H;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_IN_H: begin
        nm_we    = 1'b1;
        nm_waddr = node_r[NIW-1:0];
        nm_wdata = {1'b1, b_r, hm_rdata, NIL};
        hm_we    = 1'b1;
        hm_waddr = b_r;
        hm_wdata = node_r;
        cnt_nxt  = cnt_r + LW'(1);
        if (signed'({1'b0, b_r}) > tb_r) begin
          tb_nxt = signed'({1'b0, b_r});
        end
        if (hm_rdata != NIL) begin
          nm_raddr  = hm_rdata[NIW-1:0];
          q_nxt     = hm_rdata;
          state_nxt = S_IN_W;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_IN_W: begin
        nm_we     = 1'b1;
        nm_waddr  = q_r[NIW-1:0];
        nm_wdata  = {nm_rdata[EW-1:LW], node_r};
        state_nxt = S_DONE;
      end
      S_SC_RD: begin
        if (tb_r[BW]) begin
          state_nxt = S_DONE;
        end else begin
          hm_raddr  = tb_r[BW-1:0];
          state_nxt = S_SC_CK;
        end
      end
      S_SC_CK: begin
        if (hm_rdata == NIL) begin
          tb_nxt    = tb_r - (BW+1)'(1);
          state_nxt = S_SC_RD;
        end else begin
          node_nxt  = hm_rdata;
          found_nxt = 1'b1;
          state_nxt = S_RD_N;
        end
      end
      S_CL: begin
        nm_we    = (32'(clr_r) < NODE_COUNT);
        nm_waddr = clr_r[NIW-1:0];
        nm_wdata = '0;
        hm_we    = (32'(clr_r) < BUCKETS);
        hm_waddr = clr_r[BW-1:0];
        hm_wdata = NIL;
        clr_nxt  = clr_r + CW'(1);
        if (32'(clr_r) == SWEEP - 1) begin
          cnt_nxt   = '0;
          tb_nxt    = top_clear[BW:0];
          boot_nxt  = 1'b0;
          state_nxt = boot_r ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt      = 1'b1;
          out_nxt.found      = found_r;
          out_nxt.node_out   = found_r ? 10'(node_r) : 10'd0;
          out_nxt.gain_out   = found_r ? gout_sum[7:0] : 8'sd0;
          out_nxt.node_count = 11'(cnt_r);
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CL;
      clr_r       <= '0;
      boot_r      <= 1'b1;
      cnt_r       <= '0;
      tb_r        <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      boot_r      <= boot_nxt;
      cnt_r       <= cnt_nxt;
      tb_r        <= tb_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    node_r <= node_nxt;
    gain_r <= gain_nxt;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    b_r    <= b_nxt;
    out_r  <= out_nxt;
  end
endmodule
